// ----- src/plcr_pkg.sv -----
// shared constants and types for the color ramp unit
`default_nettype none

package plcr_pkg;

    localparam int NUM_STOPS      = 4;
    localparam int TTL_BITS       = 16;
    localparam int CHANNEL_BITS   = 8;
    localparam int NUM_CH         = 4;
    localparam int COLOR_BITS     = NUM_CH * CHANNEL_BITS;
    localparam int STOP_BITS      = TTL_BITS + COLOR_BITS;
    localparam int CFG_IDX_BITS   = $clog2(NUM_STOPS + 1);
    localparam int STOP_IDX_BITS  = $clog2(NUM_STOPS);
    localparam int COUNT_BITS     = 3;
    // register index of the stop count
    localparam int CFG_STOPS_IN_USE = NUM_STOPS;
    // dividend width: color times span plus rounding half
    localparam int NUM_BITS       = CHANNEL_BITS + TTL_BITS + 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    // one product stage plus one stage per quotient bit
    localparam int STAGES         = CHANNEL_BITS + 1;

    // one span job handed from the front to the back
    typedef struct packed {
        logic [TTL_BITS-1:0]   span;
        logic [TTL_BITS-1:0]   offset;
        logic [COLOR_BITS-1:0] color_a;
        logic [COLOR_BITS-1:0] color_b;
    } t_span_item;

endpackage

`default_nettype wire

// ----- src/plcr_ifs.sv -----
// handshake channel interfaces for the color ramp unit
`default_nettype none

interface plcr_ttl_if import plcr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TTL_BITS-1:0] particle_ttl;
    modport source (output valid, output particle_ttl, input ready);
    modport sink (input valid, input particle_ttl, output ready);
endinterface

interface plcr_color_if import plcr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] alpha;
    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface plcr_cfg_if import plcr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [STOP_BITS-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/piecewise_linear_color_ramp_unit.sv -----
// top level of the piecewise linear color ramp unit
`default_nettype none

// Maps a particle time-to-live to an RGBA color from up to four color stops.
// A new item is taken every cycle while the queue is not full: the front picks
// the bracketing stops in the accept cycle and writes the job into the queue,
// then one product stage and eight divider stages (one quotient bit each) form
// the color. A four-entry queue between front and back lets the input keep
// flowing while the output is held. No result is given while stops_in_use is
// zero. Stop registers are to be written only while idle; the block itself
// does not enforce this.

module piecewise_linear_color_ramp_unit import plcr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    plcr_cfg_if.sink     i_cfg,
    plcr_ttl_if.sink     i_ttl,
    plcr_color_if.source o_color
);

    logic       push, q_full, q_valid, take;
    t_span_item f_item, q_item;

    plcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_ttl    (i_ttl),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    plcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (take),
        .o_item  (q_item)
    );

    plcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_take  (take),
        .o_color (o_color)
    );

endmodule

`default_nettype wire

// ----- src/plcr_front.sv -----
// front: stop registers, span selection and job setup
`default_nettype none

module plcr_front import plcr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    plcr_cfg_if.sink    i_cfg,
    plcr_ttl_if.sink    i_ttl,
    input  wire logic   i_q_full,
    output logic        o_push,
    output t_span_item  o_item
);

    logic [STOP_BITS-1:0]  r_stop [NUM_STOPS];
    logic [COUNT_BITS-1:0] r_count;

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STOPS; i++) r_stop[i] <= '0;
            r_count <= '0;
        end else if (i_cfg.valid) begin
            if (32'(i_cfg.index) < NUM_STOPS) begin
                r_stop[i_cfg.index[STOP_IDX_BITS-1:0]] <= i_cfg.data;
            end else if (i_cfg.index == CFG_IDX_BITS'(CFG_STOPS_IN_USE)) begin
                r_count <= i_cfg.data[COUNT_BITS-1:0];
            end
        end
    end

    assign i_ttl.ready = !i_q_full;
    assign o_push      = i_ttl.valid && !i_q_full && (r_count != '0);

    // a: latest stop at or below ttl, b: earliest stop above ttl
    logic                  a_found, b_found;
    logic [TTL_BITS-1:0]   a_t, b_t, t_i;
    logic [COLOR_BITS-1:0] a_c, b_c;
    always_comb begin
        a_found = 1'b0;
        b_found = 1'b0;
        a_t = '0;
        b_t = '0;
        a_c = '0;
        b_c = '0;
        t_i = '0;
        for (int i = 0; i < NUM_STOPS; i++) begin
            t_i = r_stop[i][STOP_BITS-1:COLOR_BITS];
            if (32'(r_count) > 32'(i)) begin
                if (t_i <= i_ttl.particle_ttl) begin
                    if (!a_found || t_i >= a_t) begin
                        a_found = 1'b1;
                        a_t = t_i;
                        a_c = r_stop[i][COLOR_BITS-1:0];
                    end
                end else if (!b_found || t_i < b_t) begin
                    b_found = 1'b1;
                    b_t = t_i;
                    b_c = r_stop[i][COLOR_BITS-1:0];
                end
            end
        end
        // clamped ends become a unit span with zero distance
        if (!a_found || !b_found) begin
            o_item.span    = TTL_BITS'(1);
            o_item.offset  = '0;
            o_item.color_a = a_found ? a_c : b_c;
            o_item.color_b = '0;
        end else begin
            o_item.span    = b_t - a_t;
            o_item.offset  = i_ttl.particle_ttl - a_t;
            o_item.color_a = a_c;
            o_item.color_b = b_c;
        end
    end

endmodule

`default_nettype wire

// ----- src/plcr_queue.sv -----
// short job queue between front and back
`default_nettype none

module plcr_queue import plcr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_span_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  wire logic       i_pop,
    output t_span_item      o_item
);

    t_span_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_cnt;
    logic                 do_pop;

    assign o_full  = (r_cnt == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPTR_BITS+1)'(i_push) - (QPTR_BITS+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ----- src/plcr_back.sv -----
// back: weighted sums and a pipelined restoring divider per channel
`default_nettype none

module plcr_back import plcr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_span_item i_item,
    output logic            o_take,
    plcr_color_if.source    o_color
);

    logic                    r_vld  [STAGES];
    logic [TTL_BITS-1:0]     r_span [STAGES];
    logic [NUM_BITS-1:0]     r_rem  [STAGES][NUM_CH];
    logic [CHANNEL_BITS-1:0] r_quo  [STAGES][NUM_CH];
    logic [NUM_BITS-1:0]     n_rem  [STAGES][NUM_CH];
    logic [CHANNEL_BITS-1:0] n_quo  [STAGES][NUM_CH];
    logic                    en;

    assign en     = !r_vld[STAGES-1] || o_color.ready;
    assign o_take = en;

    // dividend per channel, then one quotient bit per stage
    logic [TTL_BITS-1:0]     wa;
    logic [CHANNEL_BITS-1:0] ca, cb;
    logic [NUM_BITS-1:0]     dsh;
    always_comb begin
        wa = i_item.span - i_item.offset;
        ca = '0;
        cb = '0;
        dsh = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            ca = i_item.color_a[(NUM_CH-1-c)*CHANNEL_BITS +: CHANNEL_BITS];
            cb = i_item.color_b[(NUM_CH-1-c)*CHANNEL_BITS +: CHANNEL_BITS];
            n_rem[0][c] = NUM_BITS'(ca) * NUM_BITS'(wa)
                        + NUM_BITS'(cb) * NUM_BITS'(i_item.offset)
                        + NUM_BITS'(i_item.span >> 1);
            n_quo[0][c] = '0;
        end
        for (int s = 1; s < STAGES; s++) begin
            dsh = NUM_BITS'(r_span[s-1]) << (CHANNEL_BITS - s);
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_rem[s-1][c] >= dsh) begin
                    n_rem[s][c] = r_rem[s-1][c] - dsh;
                    n_quo[s][c] = r_quo[s-1][c] | (CHANNEL_BITS'(1) << (CHANNEL_BITS - s));
                end else begin
                    n_rem[s][c] = r_rem[s-1][c];
                    n_quo[s][c] = r_quo[s-1][c];
                end
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < STAGES; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_span[0] <= i_item.span;
            for (int s = 1; s < STAGES; s++) r_span[s] <= r_span[s-1];
            for (int s = 0; s < STAGES; s++) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_rem[s][c] <= n_rem[s][c];
                    r_quo[s][c] <= n_quo[s][c];
                end
            end
        end
    end

    assign o_color.valid = r_vld[STAGES-1];
    assign o_color.red   = r_quo[STAGES-1][0];
    assign o_color.green = r_quo[STAGES-1][1];
    assign o_color.blue  = r_quo[STAGES-1][2];
    assign o_color.alpha = r_quo[STAGES-1][3];

    // divider finished with a red and alpha remainder below the span
    a_rem_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] |-> (r_rem[STAGES-1][0] < NUM_BITS'(r_span[STAGES-1]))
                         && (r_rem[STAGES-1][3] < NUM_BITS'(r_span[STAGES-1])))
        else $error("divider remainder not below span");

    // a job never enters with an empty span
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_span[0] != '0))
        else $error("zero span in back pipeline");

    // a stalled result holds its red and green channels
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STAGES-1] && !o_color.ready) |=> (r_vld[STAGES-1]
            && $stable(r_quo[STAGES-1][0]) && $stable(r_quo[STAGES-1][1])))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for the piecewise linear color ramp unit
`default_nettype none

module testbench;
    import plcr_pkg::*;

    localparam int CLK_HALF = 5;
    localparam logic [CFG_IDX_BITS-1:0] IDX_COUNT = CFG_IDX_BITS'(CFG_STOPS_IN_USE);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
    } t_rgba;

    // directed row: a config write (is_cfg) or a ttl item with optional typed result
    typedef struct {
        bit                      is_cfg;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [STOP_BITS-1:0]    data;
        logic [TTL_BITS-1:0]     ttl;
        bit                      has_exp;
        t_rgba                   exp_color;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    plcr_cfg_if   cfg_ch ();
    plcr_ttl_if   ttl_ch ();
    plcr_color_if color_ch ();

    piecewise_linear_color_ramp_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_ttl   (ttl_ch.sink),
        .o_color (color_ch.source)
    );

    // local copy of the ramp registers
    logic [STOP_BITS-1:0]  stop_regs [NUM_STOPS];
    logic [COUNT_BITS-1:0] stop_count;

    t_rgba pending_colors [$];
    int    fail_count;
    int    send_idle_pct;
    int    recv_idle_pct;

    // clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [TTL_BITS-1:0] ttl_of(logic [STOP_BITS-1:0] r);
        return r[STOP_BITS-1 -: TTL_BITS];
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] chan_of(logic [STOP_BITS-1:0] r, int c);
        return r[(3 - c) * CHANNEL_BITS +: CHANNEL_BITS];
    endfunction

    // expected color for one ttl; returns 0 when no stop is in use
    function automatic bit ramp_color(logic [TTL_BITS-1:0] ttl, output t_rgba col);
        logic [STOP_BITS-1:0] sorted [NUM_STOPS];
        logic [STOP_BITS-1:0] ra, rb, cur;
        logic [CHANNEL_BITS-1:0] ch [4];
        longint unsigned span, offs, num;
        int n, i, j;
        n = (stop_count > NUM_STOPS) ? NUM_STOPS : int'(stop_count);
        col = '0;
        if (n == 0) return 0;
        // stable insertion sort by stop time
        for (i = 0; i < n; i++) begin
            cur = stop_regs[i];
            j = i;
            while (j > 0 && ttl_of(sorted[j - 1]) > ttl_of(cur)) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = cur;
        end
        for (i = 0; i < n; i++)
            if (ttl < ttl_of(sorted[i])) break;
        if (i == 0 || i >= n) begin
            ra = (i == 0) ? sorted[0] : sorted[n - 1];
            for (j = 0; j < 4; j++) ch[j] = chan_of(ra, j);
        end else begin
            ra = sorted[i - 1];
            rb = sorted[i];
            span = ttl_of(rb) - ttl_of(ra);
            offs = ttl - ttl_of(ra);
            for (j = 0; j < 4; j++) begin
                num = chan_of(ra, j) * (span - offs) + chan_of(rb, j) * offs + span / 2;
                ch[j] = CHANNEL_BITS'(num / span);
            end
        end
        col = {ch[0], ch[1], ch[2], ch[3]};
        return 1;
    endfunction

    // valid stays high here; the next send or drain drops it
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [STOP_BITS-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx < NUM_STOPS) stop_regs[idx[STOP_IDX_BITS-1:0]] = d;
        else if (idx == IDX_COUNT) stop_count = d[COUNT_BITS-1:0];
        @(negedge i_clk);
    endtask

    // send one ttl item; queue its expected color if any
    task automatic send_ttl(input logic [TTL_BITS-1:0] ttl, input bit typed, input t_rgba tc);
        t_rgba col;
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            ttl_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        ttl_ch.valid        <= 1'b1;
        ttl_ch.particle_ttl <= ttl;
        @(posedge i_clk);
        while (!ttl_ch.ready) @(posedge i_clk);
        if (ramp_color(ttl, col)) begin
            if (typed && col !== tc)
                $error("directed row disagrees: typed %h predicted %h", tc, col);
            pending_colors.push_back(typed ? tc : col);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        ttl_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (pending_colors.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // output side: random stall and compare against oldest expectation
    always @(negedge i_clk) begin
        color_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n && color_ch.valid && color_ch.ready) begin
            if (pending_colors.size() == 0) begin
                $error("unexpected color item %h %h %h %h", color_ch.red, color_ch.green,
                       color_ch.blue, color_ch.alpha);
                fail_count++;
            end else begin
                want = pending_colors.pop_front();
                if (color_ch.red !== want.red) begin
                    $error("red: expected %0d actual %0d", want.red, color_ch.red);
                    fail_count++;
                end
                if (color_ch.green !== want.green) begin
                    $error("green: expected %0d actual %0d", want.green, color_ch.green);
                    fail_count++;
                end
                if (color_ch.blue !== want.blue) begin
                    $error("blue: expected %0d actual %0d", want.blue, color_ch.blue);
                    fail_count++;
                end
                if (color_ch.alpha !== want.alpha) begin
                    $error("alpha: expected %0d actual %0d", want.alpha, color_ch.alpha);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [STOP_BITS-1:0] rand_stop();
        logic [TTL_BITS-1:0] t;
        case ($urandom_range(3))
            0: t = '0;
            1: t = '1;
            default: t = TTL_BITS'($urandom);
        endcase
        return {t, 32'($urandom)};
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_BITS-1:0] idx, logic [STOP_BITS-1:0] d);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = d;
        return r;
    endfunction

    function automatic t_row ttl_row(logic [TTL_BITS-1:0] t, bit typed, t_rgba c);
        t_row r;
        r = '{default: '0};
        r.ttl = t;
        r.has_exp = typed;
        r.exp_color = c;
        return r;
    endfunction

    initial begin
        t_row rows [$];
        int phase, k, m, nwr;
        logic [TTL_BITS-1:0] t;
        t_rgba none_c;
        none_c = '0;
        fail_count = 0;
        send_idle_pct = 7;
        recv_idle_pct = 48;
        for (k = 0; k < NUM_STOPS; k++) stop_regs[k] = '0;
        stop_count = '0;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        ttl_ch.valid = 1'b0;
        ttl_ch.particle_ttl = '0;
        color_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: no stops, single stop, ramp, equal times, count overflow
        rows.push_back(ttl_row(16'h0000, 1'b0, none_c));
        rows.push_back(ttl_row(16'hffff, 1'b0, none_c));
        rows.push_back(cfg_row(CFG_IDX_BITS'(0), {16'h0100, 32'h00ff_80ff}));
        rows.push_back(cfg_row(CFG_IDX_BITS'(1), {16'h0300, 32'hff00_80ff}));
        rows.push_back(cfg_row(CFG_IDX_BITS'(2), {16'h0200, 32'h1020_3040}));
        rows.push_back(cfg_row(CFG_IDX_BITS'(3), {16'h0200, 32'hffff_ffff}));
        rows.push_back(cfg_row(IDX_COUNT, STOP_BITS'(1)));
        rows.push_back(ttl_row(16'h0000, 1'b1, 32'h00ff_80ff));
        rows.push_back(ttl_row(16'hffff, 1'b1, 32'h00ff_80ff));
        rows.push_back(cfg_row(IDX_COUNT, STOP_BITS'(2)));
        rows.push_back(ttl_row(16'h0000, 1'b1, 32'h00ff_80ff));
        rows.push_back(ttl_row(16'h0200, 1'b0, none_c));
        rows.push_back(ttl_row(16'h0300, 1'b1, 32'hff00_80ff));
        rows.push_back(ttl_row(16'hffff, 1'b1, 32'hff00_80ff));
        rows.push_back(ttl_row(16'h0101, 1'b0, none_c));
        rows.push_back(cfg_row(IDX_COUNT, STOP_BITS'(4)));
        rows.push_back(ttl_row(16'h01ff, 1'b0, none_c));
        rows.push_back(ttl_row(16'h0200, 1'b0, none_c));
        rows.push_back(ttl_row(16'h0280, 1'b0, none_c));
        rows.push_back(cfg_row(IDX_COUNT, STOP_BITS'(7)));
        rows.push_back(ttl_row(16'h0200, 1'b0, none_c));
        rows.push_back(ttl_row(16'haaaa, 1'b0, none_c));
        rows.push_back(ttl_row(16'h5555, 1'b0, none_c));
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                wait_drained();
                write_reg(rows[k].idx, rows[k].data);
            end else begin
                send_ttl(rows[k].ttl, rows[k].has_exp, rows[k].exp_color);
            end
        end

        // random phases: new ramp settings, then a burst of ttl items
        for (phase = 0; phase < 26; phase++) begin
            if (phase == 9) begin
                send_idle_pct = 48;
                recv_idle_pct = 7;
            end else if (phase == 18) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            nwr = $urandom_range(1, NUM_STOPS);
            for (k = 0; k < nwr; k++)
                write_reg(CFG_IDX_BITS'($urandom_range(NUM_STOPS - 1)), rand_stop());
            if (phase % 13 == 0) write_reg(IDX_COUNT, STOP_BITS'(0));
            else if (phase % 13 == 5) write_reg(IDX_COUNT, STOP_BITS'(7));
            else write_reg(IDX_COUNT, STOP_BITS'($urandom_range(1, NUM_STOPS)));
            for (m = 0; m < 50; m++) begin
                case ($urandom_range(5))
                    0: t = TTL_BITS'($urandom);
                    1: t = ttl_of(stop_regs[STOP_IDX_BITS'($urandom_range(NUM_STOPS - 1))]);
                    2: t = ttl_of(stop_regs[STOP_IDX_BITS'($urandom_range(NUM_STOPS - 1))])
                           - TTL_BITS'(1);
                    3: t = $urandom_range(1) ? '1 : '0;
                    default: t = ttl_of(stop_regs[STOP_IDX_BITS'($urandom_range(NUM_STOPS - 1))])
                                 + TTL_BITS'($urandom_range(255));
                endcase
                send_ttl(t, 1'b0, none_c);
                // hold the sender until the output side has caught up
                if (phase == 20 && m == 25)
                    wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
